>>> rtl/core/ieil_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ieil_pkg
// Shared types and constants for the indexed insert/erase list.
// ----------------------------------------------------------------------------
package ieil_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int WORD_W        = 32;
  localparam int INDEX_W       = 4;
  localparam int KIND_W        = 3;
  localparam int COUNT_W       = 5;
  localparam int ERR_W         = 2;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 3'd0,
    KIND_ERASE  = 3'd1,
    KIND_READ   = 3'd2,
    KIND_WRITE  = 3'd3,
    KIND_CLEAR  = 3'd4
  } kind_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_RANGE = 2'd2,
    ERR_EMPTY = 2'd3
  } err_t;

  typedef struct packed {
    logic               ins;
    logic               era;
    logic               wr;
    logic [INDEX_W-1:0] index;
    word_t              value;
  } cell_op_t;

endpackage

>>> rtl/core/ieil_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ieil_cell
// One list slot: takes its left neighbour on an insert below its position, its
// right neighbour on an erase at or below it, or the new value when an insert or write addresses its own position.
// ----------------------------------------------------------------------------
module ieil_cell #(
  parameter int POS   = 0,
  parameter int CMP_W = 5
) (
  input  logic              clk,
  input  ieil_pkg::cell_op_t op,
  input  ieil_pkg::word_t   left,
  input  ieil_pkg::word_t   right,
  output ieil_pkg::word_t   data
);

  logic [CMP_W-1:0] pos_c;
  logic [CMP_W-1:0] idx_c;
  logic             at_idx;
  logic             above_idx;

  assign pos_c     = CMP_W'(POS);
  assign idx_c     = CMP_W'(op.index);
  assign at_idx    = (pos_c == idx_c);
  assign above_idx = (pos_c > idx_c);

  always_ff @(posedge clk) begin
    if (op.ins) begin
      if (above_idx) begin
        data <= left;
      end else if (at_idx) begin
        data <= op.value;
      end
    end else if (op.era) begin
      if (above_idx || at_idx) begin
        data <= right;
      end
    end else if (op.wr && at_idx) begin
      data <= op.value;
    end
  end

endmodule

>>> rtl/core/indexed_insert_erase_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_insert_erase_list
// Ordered list of signed words held in a row of shifting cells, with insert,
// erase, read, write and clear operations and a status beat per request.
// ----------------------------------------------------------------------------
// Result: the result beat is registered and valid in the cycle after the request beat is accepted.
// Throughput: one request per cycle while no result beat is held by rsp_stall; every cell updates in the same cycle
//   from its neighbour, so no operation needs a second pass.
// Reset: clears the live count and the result valid; slot contents are
//   not cleared and are only read once written.
// ----------------------------------------------------------------------------
module indexed_insert_erase_list #(
  parameter int DEPTH = ieil_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic [ieil_pkg::KIND_W-1:0]         kind,
  input  logic [ieil_pkg::INDEX_W-1:0]        index,
  input  logic signed [ieil_pkg::WORD_W-1:0]  value,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic signed [ieil_pkg::WORD_W-1:0]  read_data,
  output logic [ieil_pkg::COUNT_W-1:0]        count,
  output logic                                is_empty,
  output logic [ieil_pkg::ERR_W-1:0]          error
);

  localparam int CW     = $clog2(DEPTH + 1);
  localparam int IW     = ieil_pkg::INDEX_W;
  localparam int CMP_W  = (CW > IW) ? CW : IW;
  localparam int CountW = ieil_pkg::COUNT_W;

  logic                accept;
  logic [CW-1:0]       live_count;
  logic [CW-1:0]       live_count_next;
  logic [CW-1:0]       depth_c;
  logic [CMP_W-1:0]    idx_c;
  logic [CMP_W-1:0]    cnt_c;
  ieil_pkg::err_t      err;
  ieil_pkg::word_t     sel_data;
  ieil_pkg::word_t     rd;
  ieil_pkg::cell_op_t  op_raw;
  ieil_pkg::cell_op_t  op;
  ieil_pkg::word_t     slots [DEPTH];

  assign accept    = req_valid && !req_stall;
  assign req_stall = rsp_valid && rsp_stall;
  assign depth_c   = CW'(DEPTH);
  assign idx_c     = CMP_W'(index);
  assign cnt_c     = CMP_W'(live_count);

  always_comb begin
    err             = ieil_pkg::ERR_OK;
    rd              = '0;
    live_count_next = live_count;
    op_raw          = '0;
    op_raw.index    = index;
    op_raw.value    = value;
    case (ieil_pkg::kind_t'(kind))
      ieil_pkg::KIND_INSERT: begin
        if (live_count >= depth_c) begin
          err = ieil_pkg::ERR_FULL;
        end else if (idx_c > cnt_c) begin
          err = ieil_pkg::ERR_RANGE;
        end else begin
          op_raw.ins      = 1'b1;
          live_count_next = live_count + 1'b1;
        end
      end
      ieil_pkg::KIND_ERASE: begin
        if (live_count == '0) begin
          err = ieil_pkg::ERR_EMPTY;
        end else if (idx_c >= cnt_c) begin
          err = ieil_pkg::ERR_RANGE;
        end else begin
          op_raw.era      = 1'b1;
          live_count_next = live_count - 1'b1;
        end
      end
      ieil_pkg::KIND_READ: begin
        if (live_count == '0) begin
          err = ieil_pkg::ERR_EMPTY;
        end else if (idx_c >= cnt_c) begin
          err = ieil_pkg::ERR_RANGE;
        end else begin
          rd = sel_data;
        end
      end
      ieil_pkg::KIND_WRITE: begin
        if (live_count == '0) begin
          err = ieil_pkg::ERR_EMPTY;
        end else if (idx_c >= cnt_c) begin
          err = ieil_pkg::ERR_RANGE;
        end else begin
          op_raw.wr = 1'b1;
        end
      end
      ieil_pkg::KIND_CLEAR: begin
        live_count_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    op     = op_raw;
    op.ins = op_raw.ins && accept;
    op.era = op_raw.era && accept;
    op.wr  = op_raw.wr && accept;
  end

  always_comb begin
    sel_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (CMP_W'(i) == idx_c) begin
        sel_data = sel_data | slots[i];
      end
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    ieil_pkg::word_t left;
    ieil_pkg::word_t right;

    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_inner_l
      assign left = slots[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right = slots[i];
    end else begin : g_inner_r
      assign right = slots[i+1];
    end

    ieil_cell #(
      .POS   (i),
      .CMP_W (CMP_W)
    ) u_cell (
      .clk   (clk),
      .op    (op),
      .left  (left),
      .right (right),
      .data  (slots[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live_count <= '0;
    end else if (accept) begin
      live_count <= live_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_data <= rd;
      count     <= CountW'(live_count_next);
      is_empty  <= (live_count_next == '0);
      error     <= ieil_pkg::ERR_W'(err);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    live_count <= depth_c)
    else $error("live count above depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    op.ins |=> live_count == $past(live_count) + 1'b1)
    else $error("insert did not grow the list");

  a_erase_shrinks: assert property (@(posedge clk) disable iff (rst)
    op.era |=> live_count == $past(live_count) - 1'b1)
    else $error("erase did not shrink the list");

  a_beat_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp_valid)
    else $error("accepted request gave no result beat");

  a_err_no_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && error != ieil_pkg::ERR_W'(ieil_pkg::ERR_OK) |-> read_data == '0)
    else $error("read data on failed beat");
`endif

endmodule
